// ===== rtl/assert_macros.svh =====
// assertion macros used by the fixed-point alu top module
// no dependencies; define SYNTH to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FXA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("fxa check failed");
`define FXA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fxa implication failed");
`else
`define FXA_ASSERT(lbl, clk, rst_n, prop)
`define FXA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/fxa_pkg.sv =====
// shared types and constants of the fixed-point alu
// no dependencies
package fxa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [3:0] {
		ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
		ACT_INC = 4'd4, ACT_DEC = 4'd5, ACT_LT = 4'd6, ACT_GT = 4'd7,
		ACT_LE = 4'd8, ACT_GE = 4'd9, ACT_EQ = 4'd10, ACT_NE = 4'd11,
		ACT_MAX = 4'd12, ACT_MIN = 4'd13, ACT_FROM_INT = 4'd14, ACT_TO_INT = 4'd15
	} act_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_MUL  = 2'd1,
		MODE_DIV  = 2'd2
	} mode_t;

	typedef struct packed {
		logic        valid;
		mode_t       mode;
		logic        neg;
		logic        cmp;
		logic [1:0]  st;
	} ctl_t;

	typedef struct packed {
		logic [3:0]         action;
		logic signed [31:0] a_raw;
		logic signed [31:0] b_raw;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_raw;
		logic               compare_true;
		logic [1:0]         status;
	} rsp_t;

endpackage

// ===== rtl/fixed_point_alu.sv =====
// fixed-point alu: prep stage, chain of multiply/divide cells, output stage
// depends on fxa_pkg, fxa_prep, fxa_cell, fxa_post, assert_macros.svh
//
// usage: drive req (action, a_raw, b_raw) and raise start; the word is taken
// at any edge where start is high and busy is low. busy is always low: a new
// word may enter every cycle.
// every word gives exactly one result: done is high for one cycle with rsp
// (result_raw, compare_true, status) valid, and the result must be taken then.
// every action passes the same path: one prep stage, one cell per numerator
// bit of the divider, which multiplies by shifting one multiplier bit per
// cell, and one output stage.
// throughput is one word per cycle.
// reset clears all valid flags; words in flight are dropped, no result appears.
// the receiver cannot stall, so there is no back-pressure anywhere.
`include "assert_macros.svh"
module fixed_point_alu #(
	parameter int WORD_BITS = fxa_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  fxa_pkg::req_t  req,
	output logic           done,
	output fxa_pkg::rsp_t  rsp
);
	import fxa_pkg::*;

	localparam int W = WORD_BITS;
	localparam int N = WORD_BITS + FRAC_BITS;
	localparam int LAT = N + 2;

	ctl_t           ctl [N+1];
	logic [W-1:0]   res [N+1];
	logic [N-1:0]   src [N+1];
	logic [2*W-1:0] acc [N+1];
	logic [W-1:0]   rem [N+1];
	logic [W-1:0]   mg  [N+1];

	assign busy = 1'b0;

	fxa_prep #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_prep (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.ctl(ctl[0]), .res(res[0]), .src(src[0]), .acc(acc[0]), .rem(rem[0]), .mg(mg[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		fxa_cell #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.up_ctl(ctl[i]), .up_res(res[i]), .up_src(src[i]),
			.up_acc(acc[i]), .up_rem(rem[i]), .up_mg(mg[i]),
			.ctl(ctl[i+1]), .res(res[i+1]), .src(src[i+1]),
			.acc(acc[i+1]), .rem(rem[i+1]), .mg(mg[i+1])
		);
	end

	fxa_post #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_post (
		.clk(clk), .arst_n(arst_n),
		.up_ctl(ctl[N]), .up_res(res[N]), .up_src(src[N]),
		.up_acc(acc[N]), .up_rem(rem[N]), .up_mg(mg[N]),
		.done(done), .rsp(rsp)
	);

	`FXA_ASSERT_IMPL(a_lat, clk, arst_n, start && !busy, ##LAT done)
	`FXA_ASSERT_IMPL(a_src, clk, arst_n, done, $past(start, LAT))
	`FXA_ASSERT_IMPL(a_cmp, clk, arst_n, done && rsp.compare_true, rsp.result_raw == 0)
	`FXA_ASSERT_IMPL(a_st, clk, arst_n, done, rsp.status != 2'd3)

endmodule

// ===== rtl/fxa_prep.sv =====
// operand decode and the actions computed without the cells, feeds the first cell
// depends on fxa_pkg
module fxa_prep #(
	parameter int WORD_BITS = fxa_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  fxa_pkg::req_t                     req,
	output fxa_pkg::ctl_t                     ctl,
	output logic [WORD_BITS-1:0]              res,
	output logic [WORD_BITS+FRAC_BITS-1:0]    src,
	output logic [2*WORD_BITS-1:0]            acc,
	output logic [WORD_BITS-1:0]              rem,
	output logic [WORD_BITS-1:0]              mg
);
	import fxa_pkg::*;

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int N = W + F;
	localparam logic signed [W+F:0] MAXV = (W+F+1)'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [W+F:0] MINV = -MAXV - (W+F+1)'(1);

	logic signed [W-1:0] sa, sb;
	logic                na, nb;
	logic [W-1:0]        ma, mb, tq;
	logic signed [W+F:0] wide;
	ctl_t                ctl_n;
	logic [W-1:0]        res_n, mg_n;
	logic [N-1:0]        src_n;

	always_comb begin
		sa = W'(req.a_raw);
		sb = W'(req.b_raw);
		na = sa[W-1];
		nb = sb[W-1];
		ma = na ? W'(-sa) : W'(sa);
		mb = nb ? W'(-sb) : W'(sb);
		tq = ma >> F;
		wide = '0;
		ctl_n = '0;
		ctl_n.valid = start;
		ctl_n.mode = MODE_PASS;
		ctl_n.neg = na ^ nb;
		res_n = '0;
		mg_n = '0;
		src_n = '0;
		unique case (act_t'(req.action))
			ACT_ADD: wide = (W+F+1)'(sa) + (W+F+1)'(sb);
			ACT_SUB: wide = (W+F+1)'(sa) - (W+F+1)'(sb);
			ACT_INC: wide = (W+F+1)'(sa) + (W+F+1)'(1);
			ACT_DEC: wide = (W+F+1)'(sa) - (W+F+1)'(1);
			ACT_FROM_INT: wide = (W+F+1)'(sa) <<< F;
			default: wide = '0;
		endcase
		unique case (act_t'(req.action)) inside
			ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC, ACT_FROM_INT: begin
				if (wide > MAXV) begin
					res_n = MAXV[W-1:0];
					ctl_n.st = ST_OVF;
				end else if (wide < MINV) begin
					res_n = MINV[W-1:0];
					ctl_n.st = ST_OVF;
				end else begin
					res_n = wide[W-1:0];
				end
			end
			ACT_MUL: begin
				ctl_n.mode = MODE_MUL;
				mg_n = ma;
				src_n = N'(mb);
			end
			ACT_DIV: begin
				if (mb == '0) begin
					ctl_n.st = ST_DIV0;
					res_n = (sa > 0) ? MAXV[W-1:0] : (sa < 0) ? MINV[W-1:0] : '0;
				end else begin
					ctl_n.mode = MODE_DIV;
					mg_n = mb;
					src_n = N'(ma) << F;
				end
			end
			ACT_LT: ctl_n.cmp = sa < sb;
			ACT_GT: ctl_n.cmp = sa > sb;
			ACT_LE: ctl_n.cmp = sa <= sb;
			ACT_GE: ctl_n.cmp = sa >= sb;
			ACT_EQ: ctl_n.cmp = sa == sb;
			ACT_NE: ctl_n.cmp = sa != sb;
			ACT_MAX: res_n = (sa > sb) ? sa : sb;
			ACT_MIN: res_n = (sa < sb) ? sa : sb;
			default: res_n = na ? W'(-tq) : tq;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl <= '0;
		end else begin
			ctl <= ctl_n;
		end
	end

	always_ff @(posedge clk) begin
		res <= res_n;
		src <= src_n;
		acc <= '0;
		rem <= '0;
		mg  <= mg_n;
	end

endmodule

// ===== rtl/fxa_cell.sv =====
// one step of the multiply / divide chain: one multiplier bit or one quotient bit
// depends on fxa_pkg
module fxa_cell #(
	parameter int WORD_BITS = fxa_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fxa_pkg::ctl_t                     up_ctl,
	input  logic [WORD_BITS-1:0]              up_res,
	input  logic [WORD_BITS+FRAC_BITS-1:0]    up_src,
	input  logic [2*WORD_BITS-1:0]            up_acc,
	input  logic [WORD_BITS-1:0]              up_rem,
	input  logic [WORD_BITS-1:0]              up_mg,
	output fxa_pkg::ctl_t                     ctl,
	output logic [WORD_BITS-1:0]              res,
	output logic [WORD_BITS+FRAC_BITS-1:0]    src,
	output logic [2*WORD_BITS-1:0]            acc,
	output logic [WORD_BITS-1:0]              rem,
	output logic [WORD_BITS-1:0]              mg
);
	import fxa_pkg::*;

	localparam int W = WORD_BITS;
	localparam int N = WORD_BITS + FRAC_BITS;

	logic             nbit, ge;
	logic [W-1:0]     r2;
	logic [2*W-1:0]   acc_n;

	always_comb begin
		nbit = up_src[N-1];
		// remainder stays below the divisor, so its top bit is free
		r2 = {up_rem[W-2:0], nbit};
		ge = (up_ctl.mode == MODE_DIV) && (r2 >= up_mg);
		acc_n = {up_acc[2*W-2:0], 1'b0} + (nbit ? (2*W)'(up_mg) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl <= '0;
		end else begin
			ctl <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		res <= up_res;
		src <= {up_src[N-2:0], ge};
		acc <= acc_n;
		rem <= ge ? r2 - up_mg : r2;
		mg  <= up_mg;
	end

endmodule

// ===== rtl/fxa_post.sv =====
// rounding, saturation and sign of products and quotients, pass-through of other results, output register
// depends on fxa_pkg
module fxa_post #(
	parameter int WORD_BITS = fxa_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fxa_pkg::ctl_t                     up_ctl,
	input  logic [WORD_BITS-1:0]              up_res,
	input  logic [WORD_BITS+FRAC_BITS-1:0]    up_src,
	input  logic [2*WORD_BITS-1:0]            up_acc,
	input  logic [WORD_BITS-1:0]              up_rem,
	input  logic [WORD_BITS-1:0]              up_mg,
	output logic                              done,
	output fxa_pkg::rsp_t                     rsp
);
	import fxa_pkg::*;

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int M = 2 * W + F + 1;
	localparam logic [2*W-1:0] HALF =
		(F == 0) ? '0 : ((2*W)'(1) << ((F > 0) ? F - 1 : 0));

	logic [M-1:0]        mag, lim;
	logic                over;
	logic [W-1:0]        mag_w;
	logic signed [W-1:0] res_n;
	rsp_t                rsp_n;

	always_comb begin
		if (up_ctl.mode == MODE_MUL) begin
			mag = M'((up_acc + HALF) >> F);
		end else begin
			// round half away: twice the remainder against the divisor
			mag = M'(up_src) + M'({up_rem, 1'b0} >= {1'b0, up_mg});
		end
		lim = up_ctl.neg ? (M'(1) << (W - 1)) : ((M'(1) << (W - 1)) - M'(1));
		over = mag > lim;
		mag_w = over ? lim[W-1:0] : mag[W-1:0];
		rsp_n = '0;
		if (up_ctl.mode == MODE_PASS) begin
			res_n = up_res;
			rsp_n.status = up_ctl.st;
		end else begin
			res_n = up_ctl.neg ? W'(-mag_w) : mag_w;
			rsp_n.status = over ? ST_OVF : ST_OK;
		end
		rsp_n.result_raw = 32'(res_n);
		rsp_n.compare_true = up_ctl.cmp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= up_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp <= rsp_n;
	end

endmodule

// ===== dv/tb_fixed_point_alu.sv =====
// testbench of the fixed-point alu: directed table, then random words with idle bursts
// depends on fxa_pkg and the fixed_point_alu rtl; results are checked against table values or a local predictor
module tb_fixed_point_alu;
	timeunit 1ns;
	timeprecision 1ps;
	import fxa_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = 42;
	localparam logic signed [31:0] WMAX = 32'sh7fffffff;
	localparam logic signed [31:0] WMIN = 32'sh80000000;

	typedef struct {
		act_t              act;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic              has_exp;
		rsp_t              exp;
	} row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  rsp;

	rsp_t  pending_q[$];
	int    mismatches;

	fixed_point_alu DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("fixed_point_alu regression: fail");
		$finish;
	end

	// saturate a wide signed value to the word
	function automatic rsp_t sat_word(input logic signed [127:0] v);
		rsp_t r;
		r = '0;
		if (v > WMAX) begin
			r.result_raw = WMAX;
			r.status = ST_OVF;
		end else if (v < WMIN) begin
			r.result_raw = WMIN;
			r.status = ST_OVF;
		end else begin
			r.result_raw = v[31:0];
			r.status = ST_OK;
		end
		return r;
	endfunction

	function automatic rsp_t alu_predict(input act_t act, input logic signed [31:0] a,
			input logic signed [31:0] b);
		rsp_t r;
		logic signed [127:0] sa, sb;
		logic [127:0] ma, mb, mag, q, rem;
		logic neg;
		sa = a;
		sb = b;
		ma = (a < 0) ? -sa : sa;
		mb = (b < 0) ? -sb : sb;
		neg = (a < 0) != (b < 0);
		r = '0;
		case (act)
			ACT_ADD: r = sat_word(sa + sb);
			ACT_SUB: r = sat_word(sa - sb);
			ACT_INC: r = sat_word(sa + 1);
			ACT_DEC: r = sat_word(sa - 1);
			ACT_MUL: begin
				mag = (ma * mb + (128'd1 << (FB - 1))) >> FB;
				r = sat_word(neg ? -$signed(mag) : $signed(mag));
			end
			ACT_DIV: begin
				if (mb == 0) begin
					r.status = ST_DIV0;
					r.result_raw = (a > 0) ? WMAX : (a < 0) ? WMIN : 32'sd0;
				end else begin
					q = (ma << FB) / mb;
					rem = (ma << FB) % mb;
					if (rem >= mb - rem) q = q + 1;
					r = sat_word(neg ? -$signed(q) : $signed(q));
				end
			end
			ACT_LT: r.compare_true = a < b;
			ACT_GT: r.compare_true = a > b;
			ACT_LE: r.compare_true = a <= b;
			ACT_GE: r.compare_true = a >= b;
			ACT_EQ: r.compare_true = a == b;
			ACT_NE: r.compare_true = a != b;
			ACT_MAX: r.result_raw = (a > b) ? a : b;
			ACT_MIN: r.result_raw = (a < b) ? a : b;
			ACT_FROM_INT: r = sat_word(sa <<< FB);
			default: begin
				// truncate toward zero
				mag = ma >> FB;
				r = sat_word((a < 0) ? -$signed(mag) : $signed(mag));
			end
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? WMAX - $urandom_range(0, 3) : WMIN + $urandom_range(0, 3);
			1: return $signed($urandom_range(0, 1023)) - 512;
			2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
			3: return $signed($urandom_range(0, 3)) <<< FB;
			default: return $urandom;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", rsp);
			end else begin
				rsp_t e;
				e = pending_q.pop_front();
				if (rsp.result_raw !== e.result_raw || rsp.compare_true !== e.compare_true
						|| rsp.status !== e.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp raw %h cmp %b st %0d, got raw %h cmp %b st %0d",
							e.result_raw, e.compare_true, e.status,
							rsp.result_raw, rsp.compare_true, rsp.status);
				end
			end
		end
	end

	task automatic send_word(input act_t act, input logic signed [31:0] a,
			input logic signed [31:0] b, input rsp_t exp);
		start <= 1'b1;
		req <= '{action: act, a_raw: a, b_raw: b};
		do @(posedge clk); while (busy);
		pending_q.push_back(exp);
		@(negedge clk);
	endtask

	row_t dir_tbl[$];
	row_t row;
	act_t act;
	rsp_t e;
	logic signed [31:0] a, b;
	int wait_cnt;

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		mismatches = 0;

		// add/sub saturation, mul and div cases, div by zero, inc/dec at limits, compares, max/min, int conversion, extremes
		dir_tbl.push_back('{ACT_ADD, WMAX, 32'sd1, 1, '{WMAX, 1'b0, ST_OVF}});
		dir_tbl.push_back('{ACT_SUB, WMIN, 32'sd1, 1, '{WMIN, 1'b0, ST_OVF}});
		dir_tbl.push_back('{ACT_ADD, 32'sd0, 32'sd0, 1, '{32'sd0, 1'b0, ST_OK}});
		dir_tbl.push_back('{ACT_MUL, WMAX, WMAX, 1, '{WMAX, 1'b0, ST_OVF}});
		dir_tbl.push_back('{ACT_MUL, WMIN, WMAX, 1, '{WMIN, 1'b0, ST_OVF}});
		dir_tbl.push_back('{ACT_MUL, 32'sd1, 32'sd128, 0, '0});
		dir_tbl.push_back('{ACT_MUL, -32'sd1, 32'sd128, 0, '0});
		dir_tbl.push_back('{ACT_DIV, 32'sd5, 32'sd0, 1, '{WMAX, 1'b0, ST_DIV0}});
		dir_tbl.push_back('{ACT_DIV, -32'sd5, 32'sd0, 1, '{WMIN, 1'b0, ST_DIV0}});
		dir_tbl.push_back('{ACT_DIV, 32'sd0, 32'sd0, 1, '{32'sd0, 1'b0, ST_DIV0}});
		dir_tbl.push_back('{ACT_DIV, 32'sd1, 32'sd512, 0, '0});
		dir_tbl.push_back('{ACT_DIV, WMIN, 32'sd1, 1, '{WMIN, 1'b0, ST_OVF}});
		dir_tbl.push_back('{ACT_INC, WMAX, 32'sd0, 1, '{WMAX, 1'b0, ST_OVF}});
		dir_tbl.push_back('{ACT_DEC, WMIN, 32'sd0, 1, '{WMIN, 1'b0, ST_OVF}});
		dir_tbl.push_back('{ACT_LT, WMIN, WMAX, 1, '{32'sd0, 1'b1, ST_OK}});
		dir_tbl.push_back('{ACT_GT, WMIN, WMAX, 1, '{32'sd0, 1'b0, ST_OK}});
		dir_tbl.push_back('{ACT_LE, 32'sd7, 32'sd7, 1, '{32'sd0, 1'b1, ST_OK}});
		dir_tbl.push_back('{ACT_GE, 32'sd7, 32'sd7, 1, '{32'sd0, 1'b1, ST_OK}});
		dir_tbl.push_back('{ACT_EQ, -32'sd1, -32'sd1, 1, '{32'sd0, 1'b1, ST_OK}});
		dir_tbl.push_back('{ACT_NE, -32'sd1, -32'sd1, 1, '{32'sd0, 1'b0, ST_OK}});
		dir_tbl.push_back('{ACT_MAX, WMIN, WMAX, 1, '{WMAX, 1'b0, ST_OK}});
		dir_tbl.push_back('{ACT_MIN, WMIN, WMAX, 1, '{WMIN, 1'b0, ST_OK}});
		dir_tbl.push_back('{ACT_FROM_INT, WMAX, 32'sd0, 1, '{WMAX, 1'b0, ST_OVF}});
		dir_tbl.push_back('{ACT_FROM_INT, WMIN, 32'sd0, 1, '{WMIN, 1'b0, ST_OVF}});
		dir_tbl.push_back('{ACT_TO_INT, -32'sd257, 32'sd0, 0, '0});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tbl[i]) begin
			row = dir_tbl[i];
			e = row.has_exp ? row.exp : alu_predict(row.act, row.a, row.b);
			send_word(row.act, row.a, row.b, e);
		end

		for (int n = 0; n < 1550; n++) begin
			// idle bursts, none in the last part
			if (n < 1350 && $urandom_range(0, 7) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			act = act_t'($urandom_range(0, 15));
			a = rand_operand();
			b = ($urandom_range(0, 15) == 0) ? a : rand_operand();
			if (act == ACT_DIV && $urandom_range(0, 19) == 0) b = 32'sd0;
			send_word(act, a, b, alu_predict(act, a, b));
		end
		start <= 1'b0;

		wait_cnt = 0;
		while (pending_q.size() != 0 && wait_cnt < 10 * LATENCY) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("fixed_point_alu regression: pass");
		end else begin
			$display("fixed_point_alu regression: fail");
		end
		$finish;
	end
endmodule
